/* rtl/core/psl_pkg.sv */
package psl_pkg;

    localparam int SPEC_EXPONENT_DEF = 20;

    // fixed-point layout
    localparam int DIR_FRAC = 14;
    localparam int DIR_W    = 16;
    localparam int COORD_W  = 32;
    localparam int CHAN_W   = 16;

    // scaled light vector magnitudes stay below 2^30
    localparam int MAG_W  = 30;
    localparam int RAD_W  = 2 * MAG_W + 2;
    localparam int ROOT_W = RAD_W / 2;

    // unit-vector quotient: up to 2^14
    localparam int Q_W   = DIR_FRAC + 1;
    localparam int DVD_W = MAG_W + DIR_FRAC + 1;

    // configuration port
    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;
    localparam logic [1:0] REG_LIGHT_X = 2'd0;
    localparam logic [1:0] REG_LIGHT_Y = 2'd1;
    localparam logic [1:0] REG_LIGHT_Z = 2'd2;

    typedef struct packed {
        logic [2:0][DIR_W-1:0]  n;
        logic [2:0][DIR_W-1:0]  v;
        logic [2:0][CHAN_W-1:0] col;
        logic                   lam;
        logic [15:0]            gain;
    } mat_t;

    typedef struct packed {
        logic [2:0][MAG_W-1:0] ms;
        logic [2:0]            sgn;
        logic                  zero;
        mat_t                  mat;
    } sqp_t;

    typedef struct packed {
        logic [2:0] sgn;
        logic       zero;
        mat_t       mat;
    } dvp_t;

endpackage

/* rtl/core/phong_point_light_shader.sv */
// Channel  Handshake                 Word
// in       in_valid / in_stall       point, normal, view, surface_color, lambert_on, gain
// out      out_valid / out_stall     shade_r, shade_g, shade_b
// cfg      psel/penable/pwrite       light_x @0x0, light_y @0x4, light_z @0x8
//
// One word enters per cycle while in_stall is low; it passes through the front, the
// 31-stage square root, the 16-stage divider and one multiply stage per power step.
// Reset clears only the valid bits and the light registers.
// A stall holds only the full stages in front of it; bubbles close up.
module phong_point_light_shader
    import psl_pkg::*;
#(
    parameter int SPEC_EXPONENT = SPEC_EXPONENT_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  logic [DIR_W-1:0]   normal_x,
    input  logic [DIR_W-1:0]   normal_y,
    input  logic [DIR_W-1:0]   normal_z,
    input  logic [DIR_W-1:0]   view_x,
    input  logic [DIR_W-1:0]   view_y,
    input  logic [DIR_W-1:0]   view_z,
    input  logic [47:0]        surface_color,
    input  logic               lambert_on,
    input  logic [15:0]        specular_gain,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [CHAN_W-1:0]  shade_r,
    output logic [CHAN_W-1:0]  shade_g,
    output logic [CHAN_W-1:0]  shade_b
);

    localparam int SQ_PW = $bits(sqp_t);
    localparam int DV_PW = $bits(dvp_t);

    logic [COORD_W-1:0] light_x_reg;
    logic [COORD_W-1:0] light_y_reg;
    logic [COORD_W-1:0] light_z_reg;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_x_reg <= '0;
            light_y_reg <= '0;
            light_z_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_LIGHT_X: light_x_reg <= pwdata;
                REG_LIGHT_Y: light_y_reg <= pwdata;
                REG_LIGHT_Z: light_z_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_LIGHT_X: prdata = light_x_reg;
            REG_LIGHT_Y: prdata = light_y_reg;
            REG_LIGHT_Z: prdata = light_z_reg;
            default:     prdata = '0;
        endcase
    end

    mat_t                   mat;
    logic                   fr_valid;
    logic                   fr_stall;
    logic [RAD_W-1:0]       fr_sum;
    sqp_t                   fr_pay;
    logic                   sq_valid;
    logic                   sq_stall;
    logic [ROOT_W-1:0]      sq_len;
    logic [SQ_PW-1:0]       sq_pay_vec;
    sqp_t                   sq_pay;
    dvp_t                   dv_in_pay;
    logic                   dv_valid;
    logic                   dv_stall;
    logic [2:0][Q_W-1:0]    dv_q;
    logic [DV_PW-1:0]       dv_pay_vec;
    logic [2:0][CHAN_W-1:0] shade;

    always_comb
    begin
        mat.n    = {normal_z, normal_y, normal_x};
        mat.v    = {view_z, view_y, view_x};
        mat.col  = surface_color;
        mat.lam  = lambert_on;
        mat.gain = specular_gain;
    end

    psl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .light_x   (light_x_reg),
        .light_y   (light_y_reg),
        .light_z   (light_z_reg),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .point_x   (point_x),
        .point_y   (point_y),
        .point_z   (point_z),
        .mat       (mat),
        .out_valid (fr_valid),
        .out_stall (fr_stall),
        .sum       (fr_sum),
        .pay       (fr_pay)
    );

    psl_sqrt #(.PW(SQ_PW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_stall  (fr_stall),
        .rad       (fr_sum),
        .pay_in    (fr_pay),
        .out_valid (sq_valid),
        .out_stall (sq_stall),
        .root      (sq_len),
        .pay_out   (sq_pay_vec)
    );

    assign sq_pay         = sq_pay_vec;
    assign dv_in_pay.sgn  = sq_pay.sgn;
    assign dv_in_pay.zero = sq_pay.zero;
    assign dv_in_pay.mat  = sq_pay.mat;

    psl_div #(.PW(DV_PW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_stall  (sq_stall),
        .len       (sq_len),
        .ms        (sq_pay.ms),
        .pay_in    (dv_in_pay),
        .out_valid (dv_valid),
        .out_stall (dv_stall),
        .q         (dv_q),
        .pay_out   (dv_pay_vec)
    );

    psl_shade #(.SPEC_EXPONENT(SPEC_EXPONENT)) u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_stall  (dv_stall),
        .q         (dv_q),
        .pay       (dv_pay_vec),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .shade     (shade)
    );

    assign shade_r = shade[2];
    assign shade_g = shade[1];
    assign shade_b = shade[0];

endmodule

/* rtl/core/psl_front.sv */
module psl_front
    import psl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [COORD_W-1:0] light_x,
    input  logic [COORD_W-1:0] light_y,
    input  logic [COORD_W-1:0] light_z,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [COORD_W-1:0] point_x,
    input  logic [COORD_W-1:0] point_y,
    input  logic [COORD_W-1:0] point_z,
    input  mat_t               mat,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [RAD_W-1:0]   sum,
    output sqp_t               pay
);

    localparam int NS = 5;

    typedef struct packed {
        logic [2:0][COORD_W:0]   d;
        logic [2:0]              sgn;
        logic [2:0][COORD_W:0]   mag;
        logic [2:0][MAG_W-1:0]   ms;
        logic [2:0][2*MAG_W-1:0] sq;
        logic [RAD_W-1:0]        sum;
        logic                    zero;
        mat_t                    mat;
    } fr_t;

    function automatic fr_t fr_step(input int k, input fr_t a);
        fr_t         o;
        logic [COORD_W:0] orm;
        logic [COORD_W:0] t;
        int          sh;
        o   = a;
        orm = '0;
        t   = '0;
        sh  = 0;
        if (k == 1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                o.sgn[i] = a.d[i][COORD_W];
                o.mag[i] = a.d[i][COORD_W] ? -a.d[i] : a.d[i];
            end
        end
        else if (k == 2)
        begin
            orm    = a.mag[0] | a.mag[1] | a.mag[2];
            o.zero = (orm == '0);
            if (orm[COORD_W])
                sh = 3;
            else if (orm[COORD_W-1])
                sh = 2;
            else if (orm[COORD_W-2])
                sh = 1;
            for (int i = 0; i < 3; i++)
            begin
                t       = a.mag[i] >> sh;
                o.ms[i] = t[MAG_W-1:0];
            end
        end
        else if (k == 3)
        begin
            for (int i = 0; i < 3; i++)
                o.sq[i] = (2*MAG_W)'(a.ms[i]) * (2*MAG_W)'(a.ms[i]);
        end
        else if (k == 4)
        begin
            o.sum = RAD_W'(a.sq[0]) + RAD_W'(a.sq[1]) + RAD_W'(a.sq[2]);
        end
        return o;
    endfunction

    fr_t           in_st;
    fr_t           st_reg [NS];
    fr_t           st_next [NS];
    logic [NS-1:0] v_reg;
    logic [NS:0]   go;

    always_comb
    begin
        in_st      = '0;
        in_st.d[0] = $signed({light_x[COORD_W-1], light_x})
                   - $signed({point_x[COORD_W-1], point_x});
        in_st.d[1] = $signed({light_y[COORD_W-1], light_y})
                   - $signed({point_y[COORD_W-1], point_y});
        in_st.d[2] = $signed({light_z[COORD_W-1], light_z})
                   - $signed({point_z[COORD_W-1], point_z});
        in_st.mat  = mat;
    end

    assign go[NS] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            assign go[k] = !v_reg[k] || go[k+1];
            if (k == 0)
            begin : g_first
                always_comb st_next[k] = fr_step(k, in_st);
            end
            else
            begin : g_rest
                always_comb st_next[k] = fr_step(k, st_reg[k-1]);
            end
            always_ff @(posedge clk)
            begin
                if (go[k])
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (go[i])
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
            end
        end
    end

    assign in_stall  = !go[0];
    assign out_valid = v_reg[NS-1];
    assign sum       = st_reg[NS-1].sum;
    assign pay.ms    = st_reg[NS-1].ms;
    assign pay.sgn   = st_reg[NS-1].sgn;
    assign pay.zero  = st_reg[NS-1].zero;
    assign pay.mat   = st_reg[NS-1].mat;

endmodule

/* rtl/core/psl_sqrt.sv */
module psl_sqrt
    import psl_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [RAD_W-1:0]  rad,
    input  logic [PW-1:0]     pay_in,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [ROOT_W-1:0] root,
    output logic [PW-1:0]     pay_out
);

    localparam int NS = ROOT_W;

    typedef struct packed {
        logic [RAD_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [PW-1:0]     pay;
    } sq_t;

    // one root bit per stage, MSB first
    function automatic sq_t sq_step(input int k, input sq_t a);
        sq_t          o;
        logic [RAD_W:0] trial;
        int           b;
        o     = a;
        b     = ROOT_W - 1 - k;
        trial = ({{(RAD_W + 1 - ROOT_W){1'b0}}, a.root} << (b + 1))
              + ((RAD_W + 1)'(1) << (2 * b));
        if ({1'b0, a.rem} >= trial)
        begin
            o.rem     = a.rem - trial[RAD_W-1:0];
            o.root[b] = 1'b1;
        end
        return o;
    endfunction

    sq_t           in_st;
    sq_t           st_reg [NS];
    sq_t           st_next [NS];
    logic [NS-1:0] v_reg;
    logic [NS:0]   go;

    always_comb
    begin
        in_st.rem  = rad;
        in_st.root = '0;
        in_st.pay  = pay_in;
    end

    assign go[NS] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            assign go[k] = !v_reg[k] || go[k+1];
            if (k == 0)
            begin : g_first
                always_comb st_next[k] = sq_step(k, in_st);
            end
            else
            begin : g_rest
                always_comb st_next[k] = sq_step(k, st_reg[k-1]);
            end
            always_ff @(posedge clk)
            begin
                if (go[k])
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (go[i])
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
            end
        end
    end

    assign in_stall  = !go[0];
    assign out_valid = v_reg[NS-1];
    assign root      = st_reg[NS-1].root;
    assign pay_out   = st_reg[NS-1].pay;

endmodule

/* rtl/core/psl_div.sv */
module psl_div
    import psl_pkg::*;
#(
    parameter int PW = 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [ROOT_W-1:0]     len,
    input  logic [2:0][MAG_W-1:0] ms,
    input  logic [PW-1:0]         pay_in,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [2:0][Q_W-1:0]   q,
    output logic [PW-1:0]         pay_out
);

    localparam int NS = Q_W + 1;

    typedef struct packed {
        logic [ROOT_W-1:0]       len;
        logic [2:0][DVD_W-1:0]   rem;
        logic [2:0][Q_W-1:0]     q;
        logic [PW-1:0]           pay;
    } dv_t;

    // three lanes, one quotient bit per stage after the first, which only registers the dividend
    function automatic dv_t dv_step(input int k, input dv_t a);
        dv_t            o;
        logic [DVD_W:0] dsr;
        int             b;
        o   = a;
        b   = Q_W - k;
        dsr = '0;
        if (k > 0)
        begin
            dsr = (DVD_W + 1)'(a.len) << b;
            for (int i = 0; i < 3; i++)
            begin
                if ({1'b0, a.rem[i]} >= dsr)
                begin
                    o.rem[i]  = a.rem[i] - dsr[DVD_W-1:0];
                    o.q[i][b] = 1'b1;
                end
            end
        end
        return o;
    endfunction

    dv_t           in_st;
    dv_t           st_reg [NS];
    dv_t           st_next [NS];
    logic [NS-1:0] v_reg;
    logic [NS:0]   go;

    // dividend: mag * 2^14 plus half the divisor for rounding
    always_comb
    begin
        in_st.len = len;
        in_st.q   = '0;
        in_st.pay = pay_in;
        for (int i = 0; i < 3; i++)
            in_st.rem[i] = DVD_W'({ms[i], {DIR_FRAC{1'b0}}}) + DVD_W'(len >> 1);
    end

    assign go[NS] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            assign go[k] = !v_reg[k] || go[k+1];
            if (k == 0)
            begin : g_first
                always_comb st_next[k] = dv_step(k, in_st);
            end
            else
            begin : g_rest
                always_comb st_next[k] = dv_step(k, st_reg[k-1]);
            end
            always_ff @(posedge clk)
            begin
                if (go[k])
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (go[i])
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
            end
        end
    end

    assign in_stall  = !go[0];
    assign out_valid = v_reg[NS-1];
    assign q         = st_reg[NS-1].q;
    assign pay_out   = st_reg[NS-1].pay;

endmodule

/* rtl/core/psl_shade.sv */
module psl_shade
    import psl_pkg::*;
#(
    parameter int SPEC_EXPONENT = SPEC_EXPONENT_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0][Q_W-1:0]  q,
    input  dvp_t                 pay,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0][CHAN_W-1:0] shade
);

    localparam int NS    = SPEC_EXPONENT + 11;
    localparam int P_BEG = 7;
    localparam int P_END = P_BEG + SPEC_EXPONENT - 1;

    typedef struct packed {
        dvp_t               pay;
        logic [2:0][Q_W-1:0] q;
        logic [2:0][15:0]   l;
        logic [2:0][31:0]   np;
        logic [19:0]        nl;
        logic [2:0][36:0]   rp;
        logic [2:0][23:0]   r;
        logic [2:0][39:0]   vp;
        logic [15:0]        b;
        logic [31:0]        p;
        logic [47:0]        sp;
        logic [31:0]        s;
        logic [2:0][47:0]   cs;
        logic [2:0][32:0]   cd;
        logic [2:0][15:0]   shade;
    } shd_t;

    function automatic shd_t shd_step(input int k, input shd_t a);
        shd_t               o;
        logic [15:0]        lq;
        logic signed [31:0] m32;
        logic signed [33:0] s34;
        logic signed [36:0] m37;
        logic [36:0]        t37;
        logic [22:0]        rnd;
        logic signed [39:0] m40;
        logic signed [41:0] s42;
        logic [27:0]        vr;
        logic [47:0]        m48;
        logic [33:0]        t34;
        logic [35:0]        t36;
        logic [16:0]        dnl;
        logic [32:0]        y33;
        logic [34:0]        acc;
        o   = a;
        lq  = '0;
        m32 = '0;
        s34 = '0;
        m37 = '0;
        t37 = '0;
        rnd = '0;
        m40 = '0;
        s42 = '0;
        vr  = '0;
        m48 = '0;
        t34 = '0;
        t36 = '0;
        dnl = '0;
        y33 = '0;
        acc = '0;
        if (k == 0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lq      = {1'b0, a.q[i]};
                o.l[i]  = a.pay.sgn[i] ? -lq : lq;
            end
        end
        else if (k == 1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m32      = $signed(a.pay.mat.n[i]) * $signed(a.l[i]);
                o.np[i]  = m32;
            end
        end
        else if (k == 2)
        begin
            s34  = $signed({{2{a.np[0][31]}}, a.np[0]})
                 + $signed({{2{a.np[1][31]}}, a.np[1]})
                 + $signed({{2{a.np[2][31]}}, a.np[2]})
                 + 34'sd8192;
            o.nl = s34[33:DIR_FRAC];
        end
        else if (k == 3)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m37     = $signed(a.nl) * $signed(a.pay.mat.n[i]);
                o.rp[i] = m37 <<< 1;
            end
        end
        else if (k == 4)
        begin
            for (int i = 0; i < 3; i++)
            begin
                t37    = a.rp[i] + 37'd8192;
                rnd    = t37[36:DIR_FRAC];
                o.r[i] = $signed({{8{a.l[i][15]}}, a.l[i]}) - $signed({rnd[22], rnd});
            end
        end
        else if (k == 5)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m40     = $signed(a.pay.mat.v[i]) * $signed(a.r[i]);
                o.vp[i] = m40;
            end
        end
        else if (k == 6)
        begin
            s42 = $signed({{2{a.vp[0][39]}}, a.vp[0]})
                + $signed({{2{a.vp[1][39]}}, a.vp[1]})
                + $signed({{2{a.vp[2][39]}}, a.vp[2]})
                + 42'sd8192;
            vr  = s42[41:DIR_FRAC];
            // a base of zero drives the power to zero after one step
            if (vr[27] || vr == '0)
                o.b = '0;
            else if (vr[26:16] != '0)
                o.b = 16'hFFFF;
            else
                o.b = vr[15:0];
            o.p = 32'd16384;
        end
        else if (k >= P_BEG && k <= P_END)
        begin
            m48 = 48'(a.p) * 48'(a.b) + 48'd8192;
            t34 = m48[47:DIR_FRAC];
            o.p = (t34[33:32] != 2'b00) ? 32'hFFFF_FFFF : t34[31:0];
        end
        else if (k == P_END + 1)
        begin
            o.sp = 48'(a.p) * 48'(a.pay.mat.gain);
        end
        else if (k == P_END + 2)
        begin
            m48 = a.sp + 48'd2048;
            t36 = m48[47:12];
            o.s = (t36[35:32] != 4'd0) ? 32'hFFFF_FFFF : t36[31:0];
        end
        else if (k == P_END + 3)
        begin
            if (a.pay.mat.lam && !a.nl[19] && a.nl != '0)
                dnl = a.nl[16:0];
            for (int i = 0; i < 3; i++)
            begin
                o.cs[i] = 48'(a.pay.mat.col[i]) * 48'(a.s);
                o.cd[i] = 33'(a.pay.mat.col[i]) * 33'(dnl);
            end
        end
        else if (k == P_END + 4)
        begin
            for (int i = 0; i < 3; i++)
            begin
                m48 = a.cs[i] + 48'd8192;
                y33 = a.cd[i] + 33'd8192;
                acc = 35'(m48[47:DIR_FRAC]) + 35'(y33[32:DIR_FRAC]);
                if (a.pay.zero)
                    o.shade[i] = '0;
                else if (acc[34:16] != '0)
                    o.shade[i] = 16'hFFFF;
                else
                    o.shade[i] = acc[15:0];
            end
        end
        return o;
    endfunction

    shd_t          in_st;
    shd_t          st_reg [NS];
    shd_t          st_next [NS];
    logic [NS-1:0] v_reg;
    logic [NS:0]   go;

    always_comb
    begin
        in_st     = '0;
        in_st.pay = pay;
        in_st.q   = q;
    end

    assign go[NS] = !out_stall;

    genvar k;
    generate
        for (k = 0; k < NS; k++)
        begin : g_stage
            assign go[k] = !v_reg[k] || go[k+1];
            if (k == 0)
            begin : g_first
                always_comb st_next[k] = shd_step(k, in_st);
            end
            else
            begin : g_rest
                always_comb st_next[k] = shd_step(k, st_reg[k-1]);
            end
            always_ff @(posedge clk)
            begin
                if (go[k])
                    st_reg[k] <= st_next[k];
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            for (int i = 0; i < NS; i++)
            begin
                if (go[i])
                    v_reg[i] <= (i == 0) ? in_valid : v_reg[i-1];
            end
        end
    end

    assign in_stall  = !go[0];
    assign out_valid = v_reg[NS-1];
    assign shade     = st_reg[NS-1].shade;

endmodule
